// ===== hw/rtl/slns_pkg.sv =====
// Shared constants, command codes and types for the line set snap block.
// Depends on nothing; imported by the neighbor tree and the top level.
`timescale 1ns / 1ps
`default_nettype none

package slns_pkg;

   localparam int MAX_LINES   = 64;
   localparam int POS_BITS    = 16;
   localparam int POS_FIELD_W = 16;
   // stored positions keep only the used low bits of the field
   localparam int LINE_W      = (POS_BITS < POS_FIELD_W) ? POS_BITS : POS_FIELD_W;
   localparam int IDX_BITS    = $clog2(MAX_LINES);
   localparam int TREE_LEAVES = 1 << IDX_BITS;

   localparam int THR_W = 16;
   localparam logic [THR_W-1:0] THR_RESET = 16'd16;

   localparam int CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   localparam int RSP_DATA_W = 24;

   typedef struct packed {
      logic              have_hi;
      logic [LINE_W-1:0] hi;
      logic              have_lo;
      logic [LINE_W-1:0] lo;
   } neighbor_type;

   // packed so that changed lands in bit 0
   typedef struct packed {
      logic                   table_full;
      logic [POS_FIELD_W-1:0] nearest_line;
      logic                   found;
      logic                   changed;
   } rsp_type;

   localparam int RSP_BITS = $bits(rsp_type);

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_line_set_nearest_snap.sv =====
// Line set with nearest snap: insert, erase and threshold-limited nearest search.
// An item passes the stage 1 register, then the result register; one item per cycle
//   while rsp_tready is high, via a combinational compare and reduction over all slots.
// Reset (synchronous, active high) empties the set, drops in-flight items and
//   sets snap_threshold to 16. Uses slns_pkg and slns_neighbor_tree.
`timescale 1ns / 1ps
`default_nettype none

module sorted_line_set_nearest_snap (
   input  logic                              clock,
   input  logic                              reset,
   // config: snap_threshold
   input  logic                              csr_wr_en,
   input  logic [slns_pkg::THR_W-1:0]        csr_wr_data,
   // input item
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [slns_pkg::POS_FIELD_W-1:0]  req_tdata,   // [15:0] position
   input  logic [slns_pkg::CMD_W-1:0]        req_tuser,   // [1:0] cmd
   // result item
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] changed, [1] found, [17:2] nearest_line, [18] table_full, [23:19] zero
   output logic [slns_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import slns_pkg::*;

   // ---- stage 1: registered input item ----
   logic              s1_valid_ff;
   logic [CMD_W-1:0]  s1_cmd_ff;
   logic [LINE_W-1:0] s1_pos_ff;

   // ---- set storage: values have no reset, valid bits do ----
   logic [LINE_W-1:0]    line_value_ff [MAX_LINES];
   logic [MAX_LINES-1:0] line_valid_ff;
   logic [MAX_LINES-1:0] line_valid_in;

   logic [THR_W-1:0] thr_ff;

   // ---- result register ----
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic                 advance;
   logic [MAX_LINES-1:0] match_vec;
   logic                 any_match;
   logic [MAX_LINES-1:0] free_onehot;
   logic [MAX_LINES-1:0] wr_vec;
   logic                 set_full;
   neighbor_type         nb;
   logic [THR_W-1:0]     dist_hi;
   logic [THR_W-1:0]     dist_lo;

   // stage 1 moves into the result register when that one is free or draining
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_comb begin
      for (int i = 0; i < MAX_LINES; i++) begin
         match_vec[i] = line_valid_ff[i] && (line_value_ff[i] == s1_pos_ff);
      end
   end
   assign any_match = |match_vec;
   assign set_full  = &line_valid_ff;
   // lowest clear bit, one-hot; zero when every slot is in use
   assign free_onehot = ~line_valid_ff & (line_valid_ff + {{(MAX_LINES-1){1'b0}}, 1'b1});

   slns_neighbor_tree u_tree (
      .line_valid (line_valid_ff),
      .line_value (line_value_ff),
      .query      (s1_pos_ff),
      .neighbor   (nb)
   );

   assign dist_hi = THR_W'(nb.hi - s1_pos_ff);
   assign dist_lo = THR_W'(s1_pos_ff - nb.lo);

   always_comb begin
      rsp_in        = '0;
      line_valid_in = line_valid_ff;
      wr_vec        = '0;
      unique case (s1_cmd_ff)
         CMD_INSERT: begin
            if (!any_match) begin
               if (set_full) begin
                  rsp_in.table_full = 1'b1;
               end else begin
                  wr_vec          = free_onehot;
                  line_valid_in   = line_valid_ff | free_onehot;
                  rsp_in.changed  = 1'b1;
               end
            end
         end
         CMD_ERASE: begin
            line_valid_in  = line_valid_ff & ~match_vec;
            rsp_in.changed = any_match;
         end
         CMD_SEARCH: begin
            // a tie between two neighbors reports nothing
            priority if (nb.have_hi && !nb.have_lo) begin
               if (dist_hi < thr_ff) begin
                  rsp_in.found        = 1'b1;
                  rsp_in.nearest_line = POS_FIELD_W'(nb.hi);
               end
            end else if (nb.have_lo && !nb.have_hi) begin
               if (dist_lo < thr_ff) begin
                  rsp_in.found        = 1'b1;
                  rsp_in.nearest_line = POS_FIELD_W'(nb.lo);
               end
            end else if (nb.have_hi && nb.have_lo) begin
               if (dist_hi < dist_lo && dist_hi < thr_ff) begin
                  rsp_in.found        = 1'b1;
                  rsp_in.nearest_line = POS_FIELD_W'(nb.hi);
               end else if (dist_lo < dist_hi && dist_lo < thr_ff) begin
                  rsp_in.found        = 1'b1;
                  rsp_in.nearest_line = POS_FIELD_W'(nb.lo);
               end
            end else begin
               // empty set: nothing found
               rsp_in.found = 1'b0;
            end
         end
         default: begin
            // unused code: no change, all-zero result
            rsp_in = '0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         line_valid_ff <= '0;
         thr_ff        <= THR_RESET;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff  <= 1'b1;
            line_valid_ff <= line_valid_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_cmd_ff <= req_tuser;
         s1_pos_ff <= req_tdata[LINE_W-1:0];
      end
      if (advance) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < MAX_LINES; i++) begin
            if (wr_vec[i]) begin
               line_value_ff[i] <= s1_pos_ff;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_BITS){1'b0}}, rsp_ff};

   // ---- assertions ----
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled while result register empty");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_cmd_ff == CMD_INSERT && !any_match)
         |=> (rsp_ff.table_full == $past(set_full)))
      else $error("table_full does not track slot occupancy");

   a_grow_by_one: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(line_valid_ff) <= $past($countones(line_valid_ff)) + 1))
      else $error("more than one slot filled in a cycle");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.found && (rsp_ff.changed || rsp_ff.table_full)))
      else $error("search and update flags set together");

endmodule

`default_nettype wire

// ===== hw/rtl/slns_neighbor_tree.sv =====
// Balanced compare tree: smallest stored value at or above the query and
// largest stored value below it. Uses slns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slns_neighbor_tree (
   input  logic [slns_pkg::MAX_LINES-1:0] line_valid,
   input  logic [slns_pkg::LINE_W-1:0]    line_value [slns_pkg::MAX_LINES],
   input  logic [slns_pkg::LINE_W-1:0]    query,
   output slns_pkg::neighbor_type         neighbor
);
   import slns_pkg::*;

   // heap layout: node k combines 2k and 2k+1, leaves at TREE_LEAVES + i
   neighbor_type node [1:2*TREE_LEAVES-1];

   genvar gi;
   generate
      for (gi = 0; gi < TREE_LEAVES; gi++) begin : g_leaf
         if (gi < MAX_LINES) begin : g_real
            always_comb begin
               node[TREE_LEAVES+gi].have_hi = line_valid[gi] && (line_value[gi] >= query);
               node[TREE_LEAVES+gi].have_lo = line_valid[gi] && (line_value[gi] < query);
               node[TREE_LEAVES+gi].hi      = line_value[gi];
               node[TREE_LEAVES+gi].lo      = line_value[gi];
            end
         end else begin : g_pad
            assign node[TREE_LEAVES+gi] = '0;
         end
      end

      for (gi = 1; gi < TREE_LEAVES; gi++) begin : g_node
         always_comb begin
            neighbor_type a;
            neighbor_type b;
            a = node[2*gi];
            b = node[2*gi+1];
            node[gi].have_hi = a.have_hi || b.have_hi;
            node[gi].have_lo = a.have_lo || b.have_lo;
            if (a.have_hi && (!b.have_hi || a.hi <= b.hi)) begin
               node[gi].hi = a.hi;
            end else begin
               node[gi].hi = b.hi;
            end
            if (a.have_lo && (!b.have_lo || a.lo >= b.lo)) begin
               node[gi].lo = a.lo;
            end else begin
               node[gi].lo = b.lo;
            end
         end
      end
   endgenerate

   assign neighbor = node[1];

endmodule

`default_nettype wire
